FILE: rtl/bdpc_pkg.sv
// shared types, register indexes and reset defaults for the button press classifier
package bdpc_pkg;

  // default timestamp width inside the block
  localparam int TIME_BITS_DEF = 32;

  // widths fixed by the register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic        POLARITY_DEF      = 1'b1;
  localparam logic [7:0]  PRESS_SETTLE_DEF  = 8'd8;
  localparam logic [7:0]  RELEASE_SETTLE_DEF = 8'd18;
  localparam logic [15:0] SHORTEST_DEF      = 16'd10;
  localparam logic [15:0] LONG_PRESS_DEF    = 16'd650;
  localparam logic [15:0] LOCKOUT_DEF       = 16'd160;

  // register indexes on the write port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_POLARITY       = 3'd0,
    REG_PRESS_SETTLE   = 3'd1,
    REG_RELEASE_SETTLE = 3'd2,
    REG_SHORTEST       = 3'd3,
    REG_LONG_PRESS     = 3'd4,
    REG_LOCKOUT        = 3'd5
  } cfg_idx_t;

  // current register contents
  typedef struct packed {
    logic        polarity_active_low;
    logic [7:0]  press_settle_ms;
    logic [7:0]  release_settle_ms;
    logic [15:0] shortest_press_ms;
    logic [15:0] long_press_ms;
    logic [15:0] lockout_ms;
  } cfg_t;

  // result of one tick
  typedef struct packed {
    logic long_press_pulse;
    logic toggle_pulse;
    logic held_now;
  } result_t;

endpackage

FILE: rtl/bdpc_core.sv
// debounce and press classification state with its per-tick update logic
module bdpc_core
  import bdpc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        pin_level,
  input  logic [31:0] now_ms,
  input  cfg_t        cfg,
  output result_t     res
);

  // tracking state
  logic                 seeded;
  logic                 last_level;
  logic [TIME_BITS-1:0] last_change_time;
  logic                 is_pressed;
  logic [TIME_BITS-1:0] press_start_time;
  logic [TIME_BITS-1:0] last_toggle_time;
  logic                 long_done;

  logic                 seeded_next;
  logic                 last_level_next;
  logic [TIME_BITS-1:0] last_change_time_next;
  logic                 is_pressed_next;
  logic [TIME_BITS-1:0] press_start_time_next;
  logic [TIME_BITS-1:0] last_toggle_time_next;
  logic                 long_done_next;

  logic                 raw;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] change_el;
  logic [TIME_BITS-1:0] settle_thr;
  logic                 settled;
  logic                 press_start;
  logic                 pressed_mid;
  logic [TIME_BITS-1:0] start_mid;
  logic                 long_mid;
  logic [TIME_BITS-1:0] hold_el;
  logic [TIME_BITS-1:0] toggle_el;
  logic                 long_fire;
  logic                 toggle_ok;

  // timestamp masked to the internal width, pin mapped to pressed
  assign now_t = TIME_BITS'(now_ms);
  assign raw   = cfg.polarity_active_low ? ~pin_level : pin_level;

  // debounce: settle time measured from the last level change
  assign last_level_next       = seeded ? raw : raw;
  assign last_change_time_next = (!seeded || raw != last_level) ? now_t : last_change_time;
  assign change_el  = now_t - last_change_time_next;
  assign settle_thr = raw ? TIME_BITS'(cfg.press_settle_ms)
                          : TIME_BITS'(cfg.release_settle_ms);
  assign settled    = change_el >= settle_thr;

  // accepted press records its start
  assign press_start = raw && !is_pressed;
  assign pressed_mid = is_pressed || raw;
  assign start_mid   = press_start ? now_t : press_start_time;
  assign long_mid    = press_start ? 1'b0 : long_done;

  // hold and lockout timing
  assign hold_el   = now_t - start_mid;
  assign toggle_el = now_t - last_toggle_time;
  assign long_fire = raw && !long_mid && hold_el >= TIME_BITS'(cfg.long_press_ms);
  assign toggle_ok = !long_mid && hold_el >= TIME_BITS'(cfg.shortest_press_ms)
                     && toggle_el >= TIME_BITS'(cfg.lockout_ms);

  // next state and pulses
  always_comb begin
    seeded_next           = 1'b1;
    is_pressed_next       = is_pressed;
    press_start_time_next = press_start_time;
    last_toggle_time_next = last_toggle_time;
    long_done_next        = long_done;
    res                   = '0;
    if (!seeded) begin
      is_pressed_next       = raw;
      press_start_time_next = now_t;
      long_done_next        = 1'b0;
    end else if (settled) begin
      is_pressed_next       = pressed_mid;
      press_start_time_next = start_mid;
      long_done_next        = long_mid;
      if (long_fire) begin
        long_done_next       = 1'b1;
        res.long_press_pulse = 1'b1;
      end else if (!raw && is_pressed) begin
        is_pressed_next = 1'b0;
        if (toggle_ok) begin
          last_toggle_time_next = now_t;
          res.toggle_pulse      = 1'b1;
        end
      end
    end
    res.held_now = is_pressed_next;
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded           <= 1'b0;
      last_level       <= 1'b0;
      last_change_time <= '0;
      is_pressed       <= 1'b0;
      press_start_time <= '0;
      last_toggle_time <= '0;
      long_done        <= 1'b0;
    end else if (step) begin
      seeded           <= seeded_next;
      last_level       <= last_level_next;
      last_change_time <= last_change_time_next;
      is_pressed       <= is_pressed_next;
      press_start_time <= press_start_time_next;
      last_toggle_time <= last_toggle_time_next;
      long_done        <= long_done_next;
    end
  end

endmodule

FILE: rtl/button_debounce_press_classifier.sv
// Button debounce with short/long press classification, stream in and out.
// A result appears on the output in the cycle after its tick request is accepted.
// Throughput: one tick per cycle unless the output stalls; the state update is a single
// subtract/compare chain between the state registers and the output register.
// Reset (rst, synchronous): state cleared to unseeded, registers to their defaults,
// output empty.
module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // tick request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata    // [0] long_press_pulse, [1] toggle_pulse,
                                           // [2] held_now, [7:3] zero
);

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    step;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polarity_active_low <= POLARITY_DEF;
      cfg.press_settle_ms     <= PRESS_SETTLE_DEF;
      cfg.release_settle_ms   <= RELEASE_SETTLE_DEF;
      cfg.shortest_press_ms   <= SHORTEST_DEF;
      cfg.long_press_ms       <= LONG_PRESS_DEF;
      cfg.lockout_ms          <= LOCKOUT_DEF;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_POLARITY:       cfg.polarity_active_low <= cfg_wdata[0];
        REG_PRESS_SETTLE:   cfg.press_settle_ms     <= cfg_wdata[7:0];
        REG_RELEASE_SETTLE: cfg.release_settle_ms   <= cfg_wdata[7:0];
        REG_SHORTEST:       cfg.shortest_press_ms   <= cfg_wdata;
        REG_LONG_PRESS:     cfg.long_press_ms       <= cfg_wdata;
        REG_LOCKOUT:        cfg.lockout_ms          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // accept whenever the output register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  bdpc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pin_level (s_tdata[0]),
    .now_ms    (s_tdata[32:1]),
    .cfg       (cfg),
    .res       (res)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b0, out_res.held_now, out_res.toggle_pulse, out_res.long_press_pulse};

`ifndef SYNTH
  // the two pulses never fire on the same tick
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("long press and toggle in one result");

  // a toggle comes only with a release
  a_toggle_released: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> !m_tdata[2])
    else $error("toggle while still held");

  // a long press comes only while held
  a_long_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[2])
    else $error("long press while released");

  // every accepted request yields a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted request produced no result");
`endif

endmodule
